// ===== design/texel_format_decoder_defines.svh =====
// Assertion macros for the texel format decoder.
// Both forms expect signals named clk and rst in the scope where they are used.
`ifndef TEXEL_FORMAT_DECODER_DEFINES_SVH
`define TEXEL_FORMAT_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent checked at the same edge as the antecedent.
`define TFD_ASSERT_SAME(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Consequent checked at the following edge.
`define TFD_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define TFD_ASSERT_SAME(label, pre, post, msg)
`define TFD_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

// ===== design/tfd_pkg.sv =====
`default_nettype none

package tfd_pkg;

  localparam int PALETTE_DEPTH_DEFAULT = 16384;

  localparam int SLOT_W     = 14;
  localparam int WORD_W     = 16;
  localparam int PICK_W     = 2;
  localparam int COLOR_W    = 8;
  localparam int STATUS_W   = 2;
  localparam int FMT_W      = 4;
  localparam int PFMT_W     = 2;
  localparam int COUNT_W    = 15;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [FMT_W-1:0] {
    FMT_I4     = 4'd0,
    FMT_I8     = 4'd1,
    FMT_IA4    = 4'd2,
    FMT_IA8    = 4'd3,
    FMT_RGB565 = 4'd4,
    FMT_RGB5A3 = 4'd5,
    FMT_RGBA8  = 4'd6,
    FMT_C4     = 4'd8,
    FMT_C8     = 4'd9,
    FMT_C14X2  = 4'd10,
    FMT_CMPR   = 4'd14
  } texel_fmt_t;

  typedef enum logic [PFMT_W-1:0] {
    PAL_IA8    = 2'd0,
    PAL_RGB565 = 2'd1,
    PAL_RGB5A3 = 2'd2
  } pal_fmt_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK     = 2'd0,
    STATUS_RANGE  = 2'd1,
    STATUS_FORMAT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_TEXEL_FORMAT   = 2'd0,
    REG_PALETTE_FORMAT = 2'd1,
    REG_PALETTE_COUNT  = 2'd2
  } reg_index_t;

  // How the final stage turns a word into a colour.
  typedef enum logic [3:0] {
    CONV_ZERO,
    CONV_I4,
    CONV_I8,
    CONV_IA4,
    CONV_IA8,
    CONV_565,
    CONV_5A3,
    CONV_RGBA8,
    CONV_CMPR
  } conv_t;

  typedef struct packed {
    logic [FMT_W-1:0]   texel_format;
    logic [PFMT_W-1:0]  palette_format;
    logic [COUNT_W-1:0] palette_count;
  } cfg_t;

  typedef struct packed {
    logic [WORD_W-1:0] code;
    logic [WORD_W-1:0] second_word;
    logic [PICK_W-1:0] pick;
    logic [SLOT_W-1:0] index;
  } s1_t;

  typedef struct packed {
    conv_t             conv;
    status_t           status;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] second_word;
    logic [PICK_W-1:0] pick;
    logic              four;
  } s2_t;

endpackage

`default_nettype wire

// ===== design/texel_format_decoder.sv =====
// Texel format decoder.
// Input stream s_*: one transfer per item. tuser is the mode (0 writes a
// palette word, 1 decodes a texel); tdata carries slot, code, second word
// and the CMPR selector. Palette writes are absorbed and give no output.
// Output stream m_*: one transfer per decoded texel with RGBA8 and a status
// (0 ok, 1 palette index out of range, 2 unsupported format); a failed
// decode returns a black, transparent colour.
// Registers on the APB port: texel format at 0x0, palette format at 0x4,
// palette count at 0x8. The user must change them only while the block is
// empty; the block itself does not enforce this. The block is a three-stage
// pipeline: palette index and RAM read, format classification and range
// check, colour expansion into the output register. A new item is taken
// every cycle while the output is not stalled. The palette RAM has one
// write and one read port, so a write followed directly by a read of the
// same entry sees the new word.
// Reset empties the pipeline and clears the registers; the palette contents
// are not cleared and must be written before use. When m_tready is low with
// a result waiting, all stages hold and s_tready drops in the same cycle.
`default_nettype none
`include "texel_format_decoder_defines.svh"

module texel_format_decoder #(
  parameter int PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // slot[13:0], code[29:14], second_word[45:30], pick[47:46]
  input  logic [tfd_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode[0]
  input  logic [0:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24], status[33:32], zeros
  output logic [tfd_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tfd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [tfd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [tfd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  import tfd_pkg::*;

  localparam int                 IDX_W       = $clog2(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PALETTE_DEPTH);

  cfg_t cfg;
  logic cfg_write;

  logic              advance;
  logic              in_accept;
  logic [SLOT_W-1:0] in_slot;
  logic [WORD_W-1:0] in_code;
  logic [WORD_W-1:0] in_second;
  logic [PICK_W-1:0] in_pick;
  logic [SLOT_W-1:0] in_index;
  logic              pal_we;

  logic              v1;
  s1_t               s1;
  s1_t               s1_next;
  logic [WORD_W-1:0] pal_word;
  logic              v2;
  s2_t               s2;

  logic [COLOR_W-1:0]  red, green, blue, alpha;
  logic [STATUS_W-1:0] status;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(paddr[3:2]))
        REG_TEXEL_FORMAT:   cfg.texel_format   <= pwdata[FMT_W-1:0];
        REG_PALETTE_FORMAT: cfg.palette_format <= pwdata[PFMT_W-1:0];
        REG_PALETTE_COUNT:  cfg.palette_count  <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[3:2]))
      REG_TEXEL_FORMAT:   prdata = CFG_DATA_W'(cfg.texel_format);
      REG_PALETTE_FORMAT: prdata = CFG_DATA_W'(cfg.palette_format);
      REG_PALETTE_COUNT:  prdata = CFG_DATA_W'(cfg.palette_count);
      default:            prdata = '0;
    endcase
  end

  // The whole pipeline moves together whenever the output register is free.
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = advance;
  assign in_accept = s_tvalid && s_tready;

  assign in_slot   = s_tdata[13:0];
  assign in_code   = s_tdata[29:14];
  assign in_second = s_tdata[45:30];
  assign in_pick   = s_tdata[47:46];

  always_comb begin
    unique case (texel_fmt_t'(cfg.texel_format))
      FMT_C4:  in_index = SLOT_W'(in_code[3:0]);
      FMT_C8:  in_index = SLOT_W'(in_code[7:0]);
      default: in_index = in_code[SLOT_W-1:0];
    endcase
  end

  assign pal_we = in_accept && (s_tuser[0] == MODE_WRITE) && ({1'b0, in_slot} < DEPTH_COUNT);

  always_comb begin
    s1_next.code        = in_code;
    s1_next.second_word = in_second;
    s1_next.pick        = in_pick;
    s1_next.index       = in_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid && (s_tuser[0] == MODE_DECODE);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1 <= s1_next;
    end
  end

  // Read data is held while the pipeline stalls, so it stays aligned with s1.
  tfd_ram #(
    .WIDTH (WORD_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_slot[IDX_W-1:0]),
    .wdata (in_code),
    .re    (advance),
    .raddr (in_index[IDX_W-1:0]),
    .rdata (pal_word)
  );

  tfd_classify #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v1),
    .cfg       (cfg),
    .item      (s1),
    .pal_word  (pal_word),
    .out_valid (v2),
    .out       (s2)
  );

  tfd_color u_color (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (v2),
    .item      (s2),
    .out_valid (m_tvalid),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .alpha     (alpha),
    .status    (status)
  );

  assign m_tdata = {(OUT_DATA_W - STATUS_W - 4 * COLOR_W)'(0), status, alpha, blue, green, red};

  `TFD_ASSERT_NEXT(a_write_no_result, s_tvalid && s_tready && s_tuser[0] == MODE_WRITE, !v1, "palette write entered the decode pipeline")
  `TFD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready, $stable(v1) && $stable(v2), "pipeline moved during an output stall")
  `TFD_ASSERT_SAME(a_error_black, m_tvalid && status != STATUS_OK, m_tdata[31:0] == 32'd0, "failed decode returned a colour")

endmodule

`default_nettype wire

// ===== design/tfd_ram.sv =====
`default_nettype none

module tfd_ram #(
  parameter int WIDTH = tfd_pkg::WORD_W,
  parameter int DEPTH = tfd_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/tfd_classify.sv =====
`default_nettype none

module tfd_classify #(
  parameter int PALETTE_DEPTH = tfd_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      advance,
  input  logic                      in_valid,
  input  tfd_pkg::cfg_t             cfg,
  input  tfd_pkg::s1_t              item,
  input  logic [tfd_pkg::WORD_W-1:0] pal_word,
  output logic                      out_valid,
  output tfd_pkg::s2_t              out
);

  import tfd_pkg::*;

  localparam logic [COUNT_W-1:0] DEPTH_COUNT = COUNT_W'(PALETTE_DEPTH);

  logic [COUNT_W-1:0] count_eff;
  logic               in_range;
  s2_t                s2_next;

  always_comb begin
    count_eff = (cfg.palette_count > DEPTH_COUNT) ? DEPTH_COUNT : cfg.palette_count;
    in_range  = {1'b0, item.index} < count_eff;
  end

  always_comb begin
    s2_next.conv        = CONV_ZERO;
    s2_next.status      = STATUS_OK;
    s2_next.word        = item.code;
    s2_next.second_word = item.second_word;
    s2_next.pick        = item.pick;
    s2_next.four        = item.code > item.second_word;
    unique case (texel_fmt_t'(cfg.texel_format))
      FMT_I4:     s2_next.conv = CONV_I4;
      FMT_I8:     s2_next.conv = CONV_I8;
      FMT_IA4:    s2_next.conv = CONV_IA4;
      FMT_IA8:    s2_next.conv = CONV_IA8;
      FMT_RGB565: s2_next.conv = CONV_565;
      FMT_RGB5A3: s2_next.conv = CONV_5A3;
      FMT_RGBA8:  s2_next.conv = CONV_RGBA8;
      FMT_CMPR:   s2_next.conv = CONV_CMPR;
      FMT_C4, FMT_C8, FMT_C14X2: begin
        // The range check wins over an unusable palette format.
        s2_next.word = pal_word;
        if (!in_range) begin
          s2_next.status = STATUS_RANGE;
        end else begin
          unique case (pal_fmt_t'(cfg.palette_format))
            PAL_IA8:    s2_next.conv = CONV_IA8;
            PAL_RGB565: s2_next.conv = CONV_565;
            PAL_RGB5A3: s2_next.conv = CONV_5A3;
            default:    s2_next.status = STATUS_FORMAT;
          endcase
        end
      end
      default: s2_next.status = STATUS_FORMAT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out <= s2_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/tfd_color.sv =====
`default_nettype none

module tfd_color (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         in_valid,
  input  tfd_pkg::s2_t                 item,
  output logic                         out_valid,
  output logic [tfd_pkg::COLOR_W-1:0]  red,
  output logic [tfd_pkg::COLOR_W-1:0]  green,
  output logic [tfd_pkg::COLOR_W-1:0]  blue,
  output logic [tfd_pkg::COLOR_W-1:0]  alpha,
  output logic [tfd_pkg::STATUS_W-1:0] status
);

  import tfd_pkg::*;

  function automatic logic [COLOR_W-1:0] widen5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [COLOR_W-1:0] widen6(input logic [5:0] x);
    return {x, x[5:4]};
  endfunction

  function automatic logic [COLOR_W-1:0] widen4(input logic [3:0] x);
    return {x, x};
  endfunction

  function automatic logic [COLOR_W-1:0] widen3(input logic [2:0] x);
    return {x, x, x[2:1]};
  endfunction

  // Blend of two endpoint channels: half and half in three-colour mode,
  // otherwise five eighths of the nearer endpoint and three of the other.
  function automatic logic [COLOR_W-1:0] mix(input logic [COLOR_W-1:0] x,
                                             input logic [COLOR_W-1:0] y,
                                             input logic [PICK_W-1:0]  pick,
                                             input logic               four);
    logic [COLOR_W:0]   half;
    logic [COLOR_W+2:0] wsum;
    half = {1'b0, x} + {1'b0, y};
    if (pick == 2'd2) begin
      wsum = {1'b0, x, 2'b00} + {3'b000, x} + {2'b00, y, 1'b0} + {3'b000, y};
    end else begin
      wsum = {1'b0, y, 2'b00} + {3'b000, y} + {2'b00, x, 1'b0} + {3'b000, x};
    end
    if (!four) begin
      return half[COLOR_W:1];
    end
    return wsum[COLOR_W+2:3];
  endfunction

  logic [COLOR_W-1:0] r_next, g_next, b_next, a_next;
  logic [COLOR_W-1:0] e0_r, e0_g, e0_b, e1_r, e1_g, e1_b;

  always_comb begin
    e0_r = widen5(item.word[15:11]);
    e0_g = widen6(item.word[10:5]);
    e0_b = widen5(item.word[4:0]);
    e1_r = widen5(item.second_word[15:11]);
    e1_g = widen6(item.second_word[10:5]);
    e1_b = widen5(item.second_word[4:0]);
  end

  always_comb begin
    r_next = '0;
    g_next = '0;
    b_next = '0;
    a_next = '0;
    unique case (item.conv)
      CONV_ZERO: begin
        r_next = '0;
      end
      CONV_I4: begin
        r_next = widen4(item.word[3:0]);
        g_next = r_next;
        b_next = r_next;
        a_next = r_next;
      end
      CONV_I8: begin
        r_next = item.word[7:0];
        g_next = item.word[7:0];
        b_next = item.word[7:0];
        a_next = item.word[7:0];
      end
      CONV_IA4: begin
        r_next = widen4(item.word[3:0]);
        g_next = r_next;
        b_next = r_next;
        a_next = widen4(item.word[7:4]);
      end
      CONV_IA8: begin
        r_next = item.word[7:0];
        g_next = item.word[7:0];
        b_next = item.word[7:0];
        a_next = item.word[15:8];
      end
      CONV_565: begin
        r_next = e0_r;
        g_next = e0_g;
        b_next = e0_b;
        a_next = '1;
      end
      CONV_5A3: begin
        // The top bit chooses opaque 5-5-5 or 3-bit alpha with 4-4-4 colour.
        if (item.word[15]) begin
          r_next = widen5(item.word[14:10]);
          g_next = widen5(item.word[9:5]);
          b_next = widen5(item.word[4:0]);
          a_next = '1;
        end else begin
          r_next = widen4(item.word[11:8]);
          g_next = widen4(item.word[7:4]);
          b_next = widen4(item.word[3:0]);
          a_next = widen3(item.word[14:12]);
        end
      end
      CONV_RGBA8: begin
        r_next = item.word[7:0];
        g_next = item.second_word[15:8];
        b_next = item.second_word[7:0];
        a_next = item.word[15:8];
      end
      CONV_CMPR: begin
        if (item.pick == 2'd0) begin
          r_next = e0_r;
          g_next = e0_g;
          b_next = e0_b;
          a_next = '1;
        end else if (item.pick == 2'd1) begin
          r_next = e1_r;
          g_next = e1_g;
          b_next = e1_b;
          a_next = '1;
        end else begin
          r_next = mix(e0_r, e1_r, item.pick, item.four);
          g_next = mix(e0_g, e1_g, item.pick, item.four);
          b_next = mix(e0_b, e1_b, item.pick, item.four);
          a_next = (item.pick == 2'd2 || item.four) ? '1 : '0;
        end
      end
      default: begin
        r_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      red    <= r_next;
      green  <= g_next;
      blue   <= b_next;
      alpha  <= a_next;
      status <= item.status;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/texel_format_decoder_tb.sv =====
`timescale 1ns / 1ps

module texel_format_decoder_tb;
  import tfd_pkg::*;

  localparam int LIMIT = 200000;
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 4'hC;
  localparam logic [FMT_W-1:0] FMT_RESERVED = 4'd15;
  localparam logic [PFMT_W-1:0] PAL_RESERVED = 2'd3;
  localparam logic [PICK_W-1:0] PICK_C0 = 2'd0;
  localparam logic [PICK_W-1:0] PICK_C1 = 2'd1;
  localparam logic [PICK_W-1:0] PICK_MIX_A = 2'd2;
  localparam logic [PICK_W-1:0] PICK_MIX_B = 2'd3;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    status_t            status;
  } texel_t;

  class texel_scoreboard;
    logic [FMT_W-1:0]   texel_format;
    logic [PFMT_W-1:0]  palette_format;
    logic [COUNT_W-1:0] palette_count;
    logic [WORD_W-1:0]  palette_words [PALETTE_DEPTH_DEFAULT];
    texel_t             expected_texels [$];
    int                 errors;

    function new();
      texel_format = '0;
      palette_format = '0;
      palette_count = '0;
      errors = 0;
    endfunction

    function int pending();
      return expected_texels.size();
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      case (addr)
        {REG_TEXEL_FORMAT, 2'b00}: texel_format = value[FMT_W-1:0];
        {REG_PALETTE_FORMAT, 2'b00}: palette_format = value[PFMT_W-1:0];
        {REG_PALETTE_COUNT, 2'b00}: palette_count = value[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void check_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] value);
      logic [CFG_DATA_W-1:0] want;
      case (addr)
        {REG_TEXEL_FORMAT, 2'b00}: want = CFG_DATA_W'(texel_format);
        {REG_PALETTE_FORMAT, 2'b00}: want = CFG_DATA_W'(palette_format);
        {REG_PALETTE_COUNT, 2'b00}: want = CFG_DATA_W'(palette_count);
        default: return;
      endcase
      if (value !== want) begin
        $error("register 0x%0h: expected 0x%0h, got 0x%0h", addr, want, value);
        errors++;
      end
    endfunction

    function logic [7:0] widen5(logic [4:0] x);
      return {x, x[4:2]};
    endfunction

    function logic [7:0] widen6(logic [5:0] x);
      return {x, x[5:4]};
    endfunction

    function texel_t from_ia8(logic [WORD_W-1:0] v);
      texel_t t;
      t.red = v[7:0];
      t.green = v[7:0];
      t.blue = v[7:0];
      t.alpha = v[15:8];
      t.status = STATUS_OK;
      return t;
    endfunction

    function texel_t from_565(logic [WORD_W-1:0] v);
      texel_t t;
      t.red = widen5(v[15:11]);
      t.green = widen6(v[10:5]);
      t.blue = widen5(v[4:0]);
      t.alpha = 8'hFF;
      t.status = STATUS_OK;
      return t;
    endfunction

    function texel_t from_5a3(logic [WORD_W-1:0] v);
      texel_t t;
      t.status = STATUS_OK;
      if (v[15]) begin
        t.red = widen5(v[14:10]);
        t.green = widen5(v[9:5]);
        t.blue = widen5(v[4:0]);
        t.alpha = 8'hFF;
      end else begin
        t.red = {v[11:8], v[11:8]};
        t.green = {v[7:4], v[7:4]};
        t.blue = {v[3:0], v[3:0]};
        t.alpha = {v[14:12], v[14:12], v[14:13]};
      end
      return t;
    endfunction

    function texel_t palette_colour(logic [SLOT_W-1:0] idx);
      texel_t t;
      int in_use;
      in_use = (palette_count > PALETTE_DEPTH_DEFAULT) ? PALETTE_DEPTH_DEFAULT : palette_count;
      t = '0;
      if (idx >= in_use) begin
        t.status = STATUS_RANGE;
      end else begin
        case (palette_format)
          PAL_IA8: t = from_ia8(palette_words[idx]);
          PAL_RGB565: t = from_565(palette_words[idx]);
          PAL_RGB5A3: t = from_5a3(palette_words[idx]);
          default: t.status = STATUS_FORMAT;
        endcase
      end
      return t;
    endfunction

    function logic [7:0] blend(int a, int b, logic [PICK_W-1:0] pick, logic four);
      if (!four) return 8'((a + b) / 2);
      if (pick == PICK_MIX_A) return 8'((5 * a + 3 * b) / 8);
      return 8'((3 * a + 5 * b) / 8);
    endfunction

    function texel_t cmpr_colour(logic [WORD_W-1:0] c0, logic [WORD_W-1:0] c1,
                                 logic [PICK_W-1:0] pick);
      texel_t e0, e1, t;
      logic four;
      e0 = from_565(c0);
      e1 = from_565(c1);
      four = c0 > c1;
      if (pick == PICK_C0) return e0;
      if (pick == PICK_C1) return e1;
      t = e0;
      t.red = blend(e0.red, e1.red, pick, four);
      t.green = blend(e0.green, e1.green, pick, four);
      t.blue = blend(e0.blue, e1.blue, pick, four);
      // With ordered endpoints both mixes are opaque; otherwise the last pick is transparent.
      t.alpha = (pick == PICK_MIX_A || four) ? 8'hFF : 8'h00;
      return t;
    endfunction

    function texel_t decode_texel(logic [WORD_W-1:0] code, logic [WORD_W-1:0] second,
                                  logic [PICK_W-1:0] pick);
      texel_t t;
      t = '0;
      case (texel_format)
        FMT_I4: begin
          t.red = {code[3:0], code[3:0]};
          t.green = t.red;
          t.blue = t.red;
          t.alpha = t.red;
        end
        FMT_I8: begin
          t.red = code[7:0];
          t.green = code[7:0];
          t.blue = code[7:0];
          t.alpha = code[7:0];
        end
        FMT_IA4: begin
          t.red = {code[3:0], code[3:0]};
          t.green = t.red;
          t.blue = t.red;
          t.alpha = {code[7:4], code[7:4]};
        end
        FMT_IA8: t = from_ia8(code);
        FMT_RGB565: t = from_565(code);
        FMT_RGB5A3: t = from_5a3(code);
        FMT_RGBA8: begin
          t.red = code[7:0];
          t.green = second[15:8];
          t.blue = second[7:0];
          t.alpha = code[15:8];
        end
        FMT_C4: t = palette_colour(SLOT_W'(code[3:0]));
        FMT_C8: t = palette_colour(SLOT_W'(code[7:0]));
        FMT_C14X2: t = palette_colour(code[13:0]);
        FMT_CMPR: t = cmpr_colour(code, second, pick);
        default: t.status = STATUS_FORMAT;
      endcase
      if (t.status != STATUS_OK) begin
        t.red = '0;
        t.green = '0;
        t.blue = '0;
        t.alpha = '0;
      end
      return t;
    endfunction

    function void note_item(logic mode, logic [SLOT_W-1:0] slot, logic [WORD_W-1:0] code,
                            logic [WORD_W-1:0] second, logic [PICK_W-1:0] pick);
      if (mode == MODE_WRITE) palette_words[slot] = code;
      else expected_texels.insert(expected_texels.size(), decode_texel(code, second, pick));
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] word);
      texel_t want;
      if (expected_texels.size() == 0) begin
        $error("texel result 0x%0h arrived with no decode outstanding", word);
        errors++;
        return;
      end
      want = expected_texels.pop_front();
      compare_field("red", want.red, word[7:0]);
      compare_field("green", want.green, word[15:8]);
      compare_field("blue", want.blue, word[23:16]);
      compare_field("alpha", want.alpha, word[31:24]);
      compare_field("status", 8'(want.status), 8'(word[33:32]));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [0:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  texel_scoreboard sb;
  bit              calm = 1'b0;
  int              cycles = 0;
  bit              written [PALETTE_DEPTH_DEFAULT];
  int              written_slots [$];

  texel_format_decoder dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 10);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        sb.note_item(s_tuser[0], s_tdata[13:0], s_tdata[29:14], s_tdata[45:30], s_tdata[47:46]);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input logic mode, input logic [SLOT_W-1:0] slot,
                           input logic [WORD_W-1:0] code, input logic [WORD_W-1:0] second,
                           input logic [PICK_W-1:0] pick);
    while (!calm && $urandom_range(99) < 10) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {pick, second, code, slot};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_palette_word(input logic [SLOT_W-1:0] slot, input logic [WORD_W-1:0] word);
    if (!written[slot]) begin
      written[slot] = 1'b1;
      written_slots.insert(written_slots.size(), slot);
    end
    send_item(MODE_WRITE, slot, word, WORD_W'($urandom), PICK_W'($urandom));
  endtask

  task automatic send_decode(input logic [WORD_W-1:0] code, input logic [WORD_W-1:0] second,
                             input logic [PICK_W-1:0] pick);
    send_item(MODE_DECODE, SLOT_W'($urandom), code, second, pick);
  endtask

  // Palette writes give no result, so the task waits on past the last result to cover one still in the pipeline.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    @(negedge clk);
  endtask

  // Called at a falling edge; returns at a later falling edge with the bus idle.
  task automatic set_register(input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr, value);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    sb.check_reg(addr, readback);
    @(negedge clk);
  endtask

  // Unused upper bits of each write carry random values; the block keeps only the field.
  task automatic configure(input logic [FMT_W-1:0] fmt, input logic [PFMT_W-1:0] pfmt,
                           input logic [COUNT_W-1:0] count);
    wait_idle();
    set_register({REG_TEXEL_FORMAT, 2'b00}, ($urandom() & ~32'hF) | CFG_DATA_W'(fmt));
    set_register({REG_PALETTE_FORMAT, 2'b00}, ($urandom() & ~32'h3) | CFG_DATA_W'(pfmt));
    set_register({REG_PALETTE_COUNT, 2'b00}, ($urandom() & ~32'h7FFF) | CFG_DATA_W'(count));
  endtask

  function automatic int index_reach();
    case (sb.texel_format)
      FMT_C4: return 16;
      FMT_C8: return 256;
      FMT_C14X2: return PALETTE_DEPTH_DEFAULT;
      default: return 0;
    endcase
  endfunction

  // Redirects a lookup that would land on a valid but never written entry.
  function automatic logic [WORD_W-1:0] safe_code(logic [WORD_W-1:0] code);
    int reach, in_use, idx, candidate;
    reach = index_reach();
    if (reach == 0) return code;
    in_use = (sb.palette_count > PALETTE_DEPTH_DEFAULT) ? PALETTE_DEPTH_DEFAULT : sb.palette_count;
    idx = code & (reach - 1);
    if (idx >= in_use || written[idx]) return code;
    idx = 0;
    repeat (8) begin
      candidate = written_slots[$urandom_range(written_slots.size() - 1)];
      if (candidate < reach) idx = candidate;
    end
    return (code & ~WORD_W'(reach - 1)) | WORD_W'(idx);
  endfunction

  function automatic logic [COUNT_W-1:0] count_choice(int k);
    case (k)
      0: return 15'd0;
      1: return 15'd1;
      2: return 15'd16;
      3: return 15'd255;
      4: return 15'd256;
      5: return 15'd16384;
      6: return 15'd32767;
      default: return COUNT_W'($urandom_range(32767));
    endcase
  endfunction

  task automatic random_items(input int n);
    int reach, roll;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] code, second;
    reach = index_reach();
    repeat (n) begin
      roll = $urandom_range(99);
      code = WORD_W'($urandom);
      second = WORD_W'($urandom);
      if (roll < ((reach != 0) ? 30 : 10)) begin
        slot = ($urandom_range(1) == 0) ? SLOT_W'($urandom_range(255)) : SLOT_W'($urandom);
        send_palette_word(slot, code);
        // Reading the entry back checks that a decode after a palette write sees the new word.
        if (reach != 0 && slot < reach && roll < 10)
          send_decode((second & ~WORD_W'(reach - 1)) | WORD_W'(slot), code, PICK_W'($urandom));
      end else begin
        if (sb.texel_format == FMT_CMPR && roll >= 90) second = code;
        send_decode(safe_code(code), second, PICK_W'($urandom));
      end
    end
  endtask

  initial begin
    int p;
    logic [FMT_W-1:0] fmt;
    logic [PFMT_W-1:0] pfmt;
    logic [COUNT_W-1:0] count;
    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: palette corner words, wide codes, both error statuses and all CMPR picks.
    configure(FMT_C4, PAL_IA8, 15'h7FFF);
    send_palette_word(14'd0, 16'hFFFF);
    send_palette_word(14'd15, 16'h0000);
    send_palette_word(14'h3FFF, 16'h8000);
    send_palette_word(14'd255, 16'h7FFF);
    send_palette_word(14'd1, 16'h5A3C);
    send_decode(16'hFFF0, 16'hFFFF, PICK_C0);
    send_decode(16'h000F, 16'h0000, PICK_MIX_B);
    configure(FMT_C14X2, PAL_RGB5A3, 15'h7FFF);
    send_decode(16'hFFFF, 16'h0000, PICK_C1);
    send_decode(16'h00FF, 16'hFFFF, PICK_MIX_A);
    send_decode(16'h4001, 16'h1234, PICK_C0);
    configure(FMT_C14X2, PAL_RESERVED, 15'h7FFF);
    send_decode(16'h0000, 16'h0000, PICK_C0);
    configure(FMT_C8, PAL_RGB565, 15'd0);
    send_decode(16'h0000, 16'h0000, PICK_C0);
    configure(FMT_C8, PAL_RGB565, 15'd255);
    send_decode(16'hFFFF, 16'hFFFF, PICK_MIX_B);
    send_decode(16'h0001, 16'h0000, PICK_C0);
    configure(FMT_CMPR, PAL_IA8, 15'd0);
    send_decode(16'hFFFF, 16'h0000, PICK_C0);
    send_decode(16'hFFFF, 16'h0000, PICK_C1);
    send_decode(16'hFFFF, 16'h0000, PICK_MIX_A);
    send_decode(16'hFFFF, 16'h0000, PICK_MIX_B);
    send_decode(16'h0000, 16'hFFFF, PICK_MIX_A);
    send_decode(16'h0000, 16'hFFFF, PICK_MIX_B);
    send_decode(16'h7BEF, 16'h7BEF, PICK_MIX_B);
    configure(FMT_RESERVED, PAL_IA8, 15'd16);
    send_decode(16'h1234, 16'h5678, PICK_C0);
    configure(FMT_RGBA8, PAL_IA8, 15'd16);
    send_decode(16'hFFFF, 16'h0000, PICK_C0);

    // Random phases: every format code first, then palette and CMPR settings only.
    for (p = 0; p < 20; p++) begin
      if (p < 16) begin
        fmt = FMT_W'(p);
        pfmt = PFMT_W'(p % 4);
        count = count_choice((p * 3) % 8);
      end else begin
        case (p)
          16: fmt = FMT_C4;
          17: fmt = FMT_C8;
          18: fmt = FMT_C14X2;
          default: fmt = FMT_CMPR;
        endcase
        pfmt = PFMT_W'($urandom_range(3));
        count = count_choice($urandom_range(7));
      end
      calm = (p >= 8 && p <= 10);
      configure(fmt, pfmt, count);
      if (p == 5) set_register(ADDR_SPARE, $urandom());
      random_items(20);
    end
    calm = 1'b0;

    wait_idle();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/tfd_pkg.sv
design/tfd_ram.sv
design/tfd_classify.sv
design/tfd_color.sv
design/texel_format_decoder.sv
tb/sv/texel_format_decoder_tb.sv
